FILE: rtl/sha1s_pkg.sv
// Shared definitions for the SHA-1 stream hash block.
// Holds the hash constants, byte-source codes and controller/datapath structs.
// No dependencies.
package sha1s_pkg;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hefcdab89;
  localparam logic [31:0] H2_INIT = 32'h98badcfe;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] FILL_PRE_LEN = 6'd55;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] DIGEST_WORDS = 3'd5;

  // Source of the byte pushed into the block buffer
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  typedef struct packed {
    logic       push;     // shift one byte into the block buffer
    logic [1:0] src;      // byte source code
    logic [2:0] len_idx;  // length byte, 0 = most significant
    logic       load;     // copy chain words into the working words
    logic       round;    // run one compression round
    logic [6:0] rnd;      // round number
    logic       add;      // fold working words into the chain words
    logic       finish;   // capture digest and restart the message
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;     // bytes held in the block buffer
    logic       out_busy; // digest words still waiting to leave
  } sts_t;

endpackage

FILE: rtl/sha1s_ctrl.sv
// Controller state machine for the SHA-1 stream hash block.
// Sequences byte intake, padding, compression rounds and digest hand-off.
// Depends on sha1s_pkg.
module sha1s_ctrl
  import sha1s_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  input  logic in_tuser,
  input  logic in_tlast,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  // Padding phase of the current message
  localparam logic [2:0] PH_NONE = 3'd0;
  localparam logic [2:0] PH_P80  = 3'd1;
  localparam logic [2:0] PH_ZERO = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [6:0] rnd_r, rnd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= PH_NONE;
      idx_r   <= '0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      idx_r   <= idx_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ph_nxt      = ph_r;
    idx_nxt     = idx_r;
    rnd_nxt     = rnd_r;
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.len_idx = idx_r;
    cmd.rnd     = rnd_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.push = in_tuser;
          cmd.src  = SRC_DATA;
          if (in_tlast) begin
            ph_nxt = PH_P80;
          end
          if (in_tuser && sts.fill == FILL_LAST) begin
            state_nxt = ST_LOAD;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        case (ph_r)
          PH_P80:  cmd.src = SRC_PAD;
          PH_LEN:  cmd.src = SRC_LEN;
          default: cmd.src = SRC_ZERO;
        endcase
        if (ph_r == PH_LEN) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            ph_nxt = PH_DONE;
          end
        end else if (sts.fill == FILL_PRE_LEN) begin
          ph_nxt  = PH_LEN;
          idx_nxt = '0;
        end else begin
          ph_nxt = PH_ZERO;
        end
        if (sts.fill == FILL_LAST) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        case (ph_r)
          PH_NONE: state_nxt = ST_IDLE;
          PH_DONE: state_nxt = ST_FIN;
          default: state_nxt = ST_PAD;
        endcase
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          ph_nxt     = PH_NONE;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/sha1s_dp.sv
// Datapath for the SHA-1 stream hash block: block buffer and message
// schedule window, round logic, chain words, length counter, digest output.
// Depends on sha1s_pkg.
module sha1s_dp
  import sha1s_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  cmd_t         cmd,
  input  logic [7:0]   in_byte,
  output sts_t         sts,
  input  logic         out_tready,
  output logic         out_tvalid,
  output logic [31:0]  out_tdata,
  output logic         out_tlast
);

  // Byte buffer and schedule window: word j sits at [511-32j -: 32]
  logic [511:0] blk_r;
  logic [31:0]  h_r [5];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [5:0]   fill_r;
  logic [63:0]  total_r;
  logic [159:0] dg_r;
  logic [2:0]   ocnt_r;

  logic [7:0]  push_byte;
  logic [63:0] bits;
  logic [31:0] f_val, k_val, t_val, w_new, w_x;

  assign bits = {total_r[60:0], 3'b000};

  always_comb begin
    case (cmd.src)
      SRC_DATA: push_byte = in_byte;
      SRC_PAD:  push_byte = PAD_BYTE;
      SRC_LEN:  push_byte = 8'(bits >> {~cmd.len_idx, 3'b000});
      default:  push_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (cmd.rnd inside {[7'd0:7'd19]}) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_R0;
    end else if (cmd.rnd inside {[7'd20:7'd39]}) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_R1;
    end else if (cmd.rnd inside {[7'd40:7'd59]}) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_R2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_R3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + blk_r[511:480];
  assign w_x   = blk_r[95:64] ^ blk_r[255:224] ^ blk_r[447:416] ^ blk_r[511:480];
  assign w_new = {w_x[30:0], w_x[31]};

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      blk_r <= {blk_r[503:0], push_byte};
    end else if (cmd.round) begin
      blk_r <= {blk_r[479:0], w_new};
    end
    if (cmd.load) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round) begin
      a_r <= t_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
    if (cmd.finish) begin
      dg_r <= {h_r[0], h_r[1], h_r[2], h_r[3], h_r[4]};
    end else if (out_tvalid && out_tready) begin
      dg_r <= {dg_r[127:0], 32'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0]  <= H0_INIT;
      h_r[1]  <= H1_INIT;
      h_r[2]  <= H2_INIT;
      h_r[3]  <= H3_INIT;
      h_r[4]  <= H4_INIT;
      fill_r  <= '0;
      total_r <= '0;
      ocnt_r  <= '0;
    end else begin
      if (cmd.finish) begin
        h_r[0]  <= H0_INIT;
        h_r[1]  <= H1_INIT;
        h_r[2]  <= H2_INIT;
        h_r[3]  <= H3_INIT;
        h_r[4]  <= H4_INIT;
        fill_r  <= '0;
        total_r <= '0;
        ocnt_r  <= DIGEST_WORDS;
      end else begin
        if (cmd.add) begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
        end
        if (cmd.push) begin
          fill_r <= fill_r + 6'd1;
          if (cmd.src == SRC_DATA) begin
            total_r <= total_r + 64'd1;
          end
        end
        if (out_tvalid && out_tready) begin
          ocnt_r <= ocnt_r - 3'd1;
        end
      end
    end
  end

  assign sts.fill     = fill_r;
  assign sts.out_busy = (ocnt_r != 3'd0);
  assign out_tvalid   = (ocnt_r != 3'd0);
  assign out_tdata    = dg_r[159:128];
  assign out_tlast    = (ocnt_r == 3'd1);

endmodule

FILE: rtl/sha1_stream_hash.sv
// Streaming SHA-1: at most one message byte per input transaction, 160-bit digest out as
// five 32-bit big-endian words. Depends on sha1s_pkg, sha1s_ctrl, sha1s_dp.
// Intake pauses while each filled 64-byte block is compressed (load, 80 rounds at
// one per cycle, add). Closing pads 9..72 bytes plus 1 or 2 compressions, then
// captures the digest; words leave one per cycle while out_tready is high.
// Reset (rst_n low, synchronous) restores the chain, clears the length, drops output.
module sha1_stream_hash
  import sha1s_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,   // end_of_message
  // Digest channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // word_last
);

  cmd_t cmd;
  sts_t sts;

  // Controller: owns the handshake on the input side, padding phase and
  // round counter. While a digest drains, the next message is still taken;
  // only its closing waits for the output to empty.
  sha1s_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: block buffer doubling as the schedule window, round unit,
  // chain words and the digest output register.
  sha1s_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_byte    (in_tdata),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/sha1s_chk.sv
// Port-level checker for the SHA-1 stream hash block, bound to the top level.
// Depends on the top-level port list only.
module sha1s_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // Hold a stalled digest word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("digest word changed while stalled");

  // Closing a message stops intake for padding
  a_close_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken right after end of message");

  // Last word ends the digest burst
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("output valid right after last digest word");

  // Drop pending output on reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind sha1_stream_hash sha1s_chk u_sha1s_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: bench/tb_sha1_stream_hash.sv
// Self-checking bench for sha1_stream_hash: drives byte transactions, predicts each
// SHA-1 digest in-bench, and compares every digest word.
// Depends on sha1s_pkg and the sha1_stream_hash RTL.
module tb_sha1_stream_hash
  import sha1s_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 500000;
  localparam int          RANDOM_ITEMS = 400;  // message-bearing transactions to send
  localparam int          HOLD_CYCLES  = 1500; // long sink hold-off
  localparam int          DRAIN_CYCLES = 300;  // quiet time after the last digest
  localparam int          LEN_OFFSET   = 56;   // where the bit length starts in a block
  localparam int          DIR_N        = 13;

  // Directed rows either rely on the in-bench predictor or carry a digest that is
  // known by heart.
  localparam logic [1:0] KNOWN_NONE  = 2'd0;
  localparam logic [1:0] KNOWN_EMPTY = 2'd1;
  localparam logic [1:0] KNOWN_ABC   = 2'd2;

  localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam logic [159:0] ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

  typedef struct packed {
    logic [7:0] data;
    logic       bv;     // byte_valid
    logic       eom;    // end_of_message
    logic [1:0] known;  // typed-in digest selector
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata  = 8'h00;  // [7:0] data_byte
  logic        in_tuser  = 1'b0;   // [0] byte_valid
  logic        in_tlast  = 1'b0;   // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] digest_word
  logic        out_tlast;          // word_last
  logic [1:0]  drv_known = KNOWN_NONE; // travels beside the input transaction

  sha1_stream_hash dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Digest predictor: its own chaining words, block buffer, fill and byte count.
  // ---------------------------------------------------------------------------
  logic [31:0] chain_st [5];
  logic [7:0]  block_st [64];
  int unsigned fill_st;
  logic [63:0] total_st;

  digest_word_t digest_q [$];   // digest words still owed by the block

  int unsigned errors        = 0;
  int unsigned items_sent    = 0;
  int unsigned msgs_closed   = 0;
  int unsigned bytes_taken   = 0;
  int unsigned words_checked = 0;
  int unsigned cycle_count   = 0;
  bit          hold_req      = 1'b0;
  bit          burst_mode    = 1'b0;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Reload the initial chain and forget the message length.
  function automatic void restart_message();
    chain_st[0] = H0_INIT;
    chain_st[1] = H1_INIT;
    chain_st[2] = H2_INIT;
    chain_st[3] = H3_INIT;
    chain_st[4] = H4_INIT;
    fill_st  = 0;
    total_st = '0;
  endfunction

  // Run the 80 rounds over the full block and fold the result into the chain.
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {block_st[4*r], block_st[4*r+1], block_st[4*r+2], block_st[4*r+3]};
    for (int r = 16; r < 80; r++)
      w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain_st[0];
    b = chain_st[1];
    c = chain_st[2];
    d = chain_st[3];
    e = chain_st[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_R0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      t = rotl(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_st[0] += a;
    chain_st[1] += b;
    chain_st[2] += c;
    chain_st[3] += d;
    chain_st[4] += e;
  endfunction

  function automatic void append_byte(input logic [7:0] v);
    block_st[fill_st] = v;
    fill_st++;
    if (fill_st == 64) begin
      compress_block();
      fill_st = 0;
    end
  endfunction

  // Absorb one accepted transaction; return 1 with the digest when it closes a message.
  function automatic bit absorb_item(input logic [7:0] data, input logic bv,
                                     input logic eom, output logic [159:0] dig);
    logic [63:0] bit_len;
    if (bv) begin
      append_byte(data);
      total_st++;
    end
    if (!eom)
      return 1'b0;
    bit_len = total_st << 3;
    append_byte(PAD_BYTE);
    while (fill_st != LEN_OFFSET)
      append_byte(8'h00);
    for (int i = 7; i >= 0; i--)
      append_byte(bit_len[8*i +: 8]);
    dig = {chain_st[0], chain_st[1], chain_st[2], chain_st[3], chain_st[4]};
    restart_message();
    return 1'b1;
  endfunction

  // Mostly zero, some short, a few long idle stretches.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11)
      return 0;
    if (r < 18)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every input transaction, check every digest transaction.
  // Both sides are sampled at the rising edge, before any NBA of that edge lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : digest_check
    logic [159:0] dig;
    digest_word_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (in_tuser)
          bytes_taken++;
        if (absorb_item(in_tdata, in_tuser, in_tlast, dig)) begin
          msgs_closed++;
          // Directed rows with a well-known digest override the predictor.
          if (drv_known == KNOWN_EMPTY)
            dig = EMPTY_DIGEST;
          else if (drv_known == KNOWN_ABC)
            dig = ABC_DIGEST;
          for (int i = 0; i < int'(DIGEST_WORDS); i++) begin
            want.word = dig[159 - 32*i -: 32];
            want.last = (i == int'(DIGEST_WORDS) - 1);
            digest_q.push_back(want);
          end
        end
      end
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h (last %b), nothing pending",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          want = digest_q.pop_front();
          words_checked++;
          if (out_tdata !== want.word) begin
            $display("%0t: digest_word mismatch, expected %h, actual %h",
                     $time, want.word, out_tdata);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: word_last mismatch, expected %b, actual %b",
                     $time, want.last, out_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d digest words still pending", $time, digest_q.size());
      $display("sha1_stream_hash test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Digest sink: random ready/stall stretches, plus a long hold-off on request so
  // the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : digest_sink
    int run;
    int stall;
    while (!rst_n)
      @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      run   = $urandom_range(1, 20);
      stall = idle_len();
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Present one input transaction and hold it until the block takes it.
  // Keep tvalid high across back-to-back transactions; drop it only for a gap.
  task automatic send_item(input logic [7:0] data, input logic bv, input logic eom,
                           input logic [1:0] known);
    int gap;
    gap = burst_mode ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= bv;
    in_tlast  <= eom;
    drv_known <= known;
    do @(posedge clk); while (!in_tready);
    if (bv || eom)
      items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: directed table first, then random messages.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t dir_rows [DIR_N];
    int        len;
    int        msg_idx;
    int        sent_base;
    logic      eom_on_byte;

    restart_message();
    dir_rows = '{
      {8'hA5, 1'b0, 1'b1, KNOWN_EMPTY},  // end alone right after reset, data ignored
      {8'h61, 1'b1, 1'b0, KNOWN_NONE},   // "a"
      {8'hFF, 1'b0, 1'b0, KNOWN_NONE},   // no byte, no end: must change nothing
      {8'h62, 1'b1, 1'b0, KNOWN_NONE},   // "b"
      {8'h63, 1'b1, 1'b1, KNOWN_ABC},    // "c" with end on the same transaction
      {8'h00, 1'b1, 1'b0, KNOWN_NONE},   // low extreme
      {8'hFF, 1'b1, 1'b0, KNOWN_NONE},   // high extreme
      {8'h5A, 1'b0, 1'b1, KNOWN_NONE},   // end without byte after data
      {8'hFF, 1'b1, 1'b1, KNOWN_NONE},   // one-byte message
      {8'h00, 1'b0, 1'b1, KNOWN_EMPTY},  // empty message right after a digest
      {8'h80, 1'b1, 1'b0, KNOWN_NONE},   // pad pattern as data
      {8'h7F, 1'b1, 1'b0, KNOWN_NONE},
      {8'h01, 1'b1, 1'b1, KNOWN_NONE}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].data, dir_rows[i].bv, dir_rows[i].eom, dir_rows[i].known);

    // Random messages; lengths lean on the padding edges where one extra block
    // is needed for the length field.
    sent_base = items_sent;
    msg_idx   = 0;
    while (items_sent - sent_base < RANDOM_ITEMS) begin
      if (msg_idx == 3 || msg_idx == 14)
        hold_req = 1'b1;
      burst_mode = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(0, 8);
        4, 5, 6: begin
          case ($urandom_range(0, 7))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            5: len = 65;
            6: len = 119;
            default: len = 120;
          endcase
        end
        default: len = $urandom_range(9, 140);
      endcase
      eom_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        // Sprinkle in no-op transactions carrying junk data.
        if ($urandom_range(0, 11) == 0)
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, KNOWN_NONE);
        send_item(8'($urandom_range(0, 255)), 1'b1, eom_on_byte && (i == len - 1),
                  KNOWN_NONE);
      end
      if (!eom_on_byte)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, KNOWN_NONE);
      // Now and then starve the input until the block has handed over everything.
      if (msg_idx == 6 || $urandom_range(0, 9) == 0) begin
        in_tvalid <= 1'b0;
        do @(posedge clk); while (digest_q.size() != 0);
      end
      msg_idx++;
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d messages (%0d message bytes) with padding-edge lengths,",
             msgs_closed, bytes_taken);
    $display("sink hold-offs and input starvation; %0d digest words compared, %0d errors.",
             words_checked, errors);
    if (errors == 0)
      $display("sha1_stream_hash test passed");
    else
      $display("sha1_stream_hash test failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/sha1s_pkg.sv
rtl/sha1s_ctrl.sv
rtl/sha1s_dp.sv
rtl/sha1_stream_hash.sv
rtl/sha1s_chk.sv
bench/tb_sha1_stream_hash.sv
